[sv/three_phase_thyristor_firing_assert.svh]
// Assertion macros for the firing block checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef THREE_PHASE_THYRISTOR_FIRING_ASSERT_SVH
`define THREE_PHASE_THYRISTOR_FIRING_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define TPF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition in one cycle that requires another in the next cycle.
`define TPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// A sequence of cycles that requires a condition in the cycle after it ends.
`define TPF_ASSERT_SEQ(label, seq, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (seq) |=> (cons)) \
        else $error(msg);

`endif

[sv/tpf_pkg.sv]
// Package for the three-phase thyristor firing block.
// Holds angle constants, the register index codes and the configuration struct.
`timescale 1ns / 1ps

package tpf_pkg;

    // Field widths.
    localparam int ANGLE_W = 13;
    localparam int CFG_W   = 14;
    localparam int DEG_W   = 16;

    // One turn and half a turn in 1/16 degree.
    localparam logic signed [DEG_W-1:0] FULL_TURN = 16'sd5760;
    localparam logic [CFG_W-1:0]        HALF_TURN = 14'd2880;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_ALPHA_LOW   = 3'd0,
        REG_ALPHA_HIGH  = 3'd1,
        REG_PHASE_CORR  = 3'd2,
        REG_PULSE_WIDTH = 3'd3,
        REG_RESET_MARG  = 3'd4,
        REG_LATCH_MARG  = 3'd5,
        REG_POS_LIMIT   = 3'd6,
        REG_NEG_LIMIT   = 3'd7
    } cfg_index_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [ANGLE_W-1:0]        alpha_low_limit;
        logic [ANGLE_W-1:0]        alpha_high_limit;
        logic signed [CFG_W-1:0]   phase_correction;
        logic [ANGLE_W-1:0]        pulse_width;
        logic [ANGLE_W-1:0]        reset_margin;
        logic [ANGLE_W-1:0]        latch_margin;
        logic [ANGLE_W-1:0]        positive_latch_limit;
        logic [ANGLE_W-1:0]        negative_latch_limit;
    } cfg_t;

endpackage

[sv/tpf_cfg_regs.sv]
// Configuration register file of the firing block.
// Depends on tpf_pkg for the register index codes and the cfg_t struct.
`timescale 1ns / 1ps

module tpf_cfg_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [tpf_pkg::CFG_W-1:0]  cfg_data,
    output tpf_pkg::cfg_t              cfg
);

    tpf_pkg::cfg_t cfg_reg;
    tpf_pkg::cfg_t cfg_next;

    // Decode a write into the addressed register.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (tpf_pkg::cfg_index_t'(cfg_index))
                tpf_pkg::REG_ALPHA_LOW:
                    cfg_next.alpha_low_limit = cfg_data[tpf_pkg::ANGLE_W-1:0];
                tpf_pkg::REG_ALPHA_HIGH:
                    cfg_next.alpha_high_limit = cfg_data[tpf_pkg::ANGLE_W-1:0];
                tpf_pkg::REG_PHASE_CORR:
                    cfg_next.phase_correction = $signed(cfg_data);
                tpf_pkg::REG_PULSE_WIDTH:
                    cfg_next.pulse_width = cfg_data[tpf_pkg::ANGLE_W-1:0];
                tpf_pkg::REG_RESET_MARG:
                    cfg_next.reset_margin = cfg_data[tpf_pkg::ANGLE_W-1:0];
                tpf_pkg::REG_LATCH_MARG:
                    cfg_next.latch_margin = cfg_data[tpf_pkg::ANGLE_W-1:0];
                tpf_pkg::REG_POS_LIMIT:
                    cfg_next.positive_latch_limit = cfg_data[tpf_pkg::ANGLE_W-1:0];
                tpf_pkg::REG_NEG_LIMIT:
                    cfg_next.negative_latch_limit = cfg_data[tpf_pkg::ANGLE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_low_limit      <= 13'd1520;
            cfg_reg.alpha_high_limit     <= 13'd2720;
            cfg_reg.phase_correction     <= 14'sd0;
            cfg_reg.pulse_width          <= 13'd160;
            cfg_reg.reset_margin         <= 13'd160;
            cfg_reg.latch_margin         <= 13'd16;
            cfg_reg.positive_latch_limit <= 13'd5760;
            cfg_reg.negative_latch_limit <= 13'd5760;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/tpf_gate_cell.sv]
// One thyristor gate: firing angle freeze, window compare and gate state.
// Depends on tpf_pkg for widths and the cfg_t struct.
`timescale 1ns / 1ps

module tpf_gate_cell
#(
    parameter int ANGLE_BITS = 14
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic                              run,
    input  logic signed [tpf_pkg::DEG_W-1:0]  deg,
    input  logic [tpf_pkg::CFG_W-1:0]         alpha_in,
    input  logic [tpf_pkg::ANGLE_W-1:0]       limit,
    input  tpf_pkg::cfg_t                     cfg,
    output logic                              gate
);

    // Working width holds the stored angle plus a margin, with sign.
    localparam int BASE_W = (ANGLE_BITS > tpf_pkg::CFG_W) ? ANGLE_BITS : tpf_pkg::CFG_W;
    localparam int SW     = BASE_W + 3;

    logic [ANGLE_BITS-1:0] prev_reg;
    logic [ANGLE_BITS-1:0] prev_next;
    logic                  fired_reg;
    logic                  fired_next;
    logic                  freeze_reg;
    logic                  freeze_next;
    logic                  gate_reg;
    logic                  gate_next;

    logic signed [SW-1:0]  deg_s;
    logic signed [SW-1:0]  alpha_new;
    logic signed [SW-1:0]  prev_s;
    logic signed [SW-1:0]  lm_s;
    logic signed [SW-1:0]  pw_s;
    logic signed [SW-1:0]  rm_s;
    logic signed [SW-1:0]  lim_s;
    logic signed [SW-1:0]  alpha_eff;
    logic signed [SW-1:0]  win_top;
    logic                  hold;
    logic                  freeze_a;
    logic                  in_win;
    logic                  out_win;

    // Bring all operands to one signed width.
    assign deg_s     = {{(SW-tpf_pkg::DEG_W){deg[tpf_pkg::DEG_W-1]}}, deg};
    assign alpha_new = $signed({{(SW-tpf_pkg::CFG_W){1'b0}}, alpha_in});
    assign prev_s    = $signed({{(SW-ANGLE_BITS){1'b0}}, prev_reg});
    assign lm_s      = $signed({{(SW-tpf_pkg::ANGLE_W){1'b0}}, cfg.latch_margin});
    assign pw_s      = $signed({{(SW-tpf_pkg::ANGLE_W){1'b0}}, cfg.pulse_width});
    assign rm_s      = $signed({{(SW-tpf_pkg::ANGLE_W){1'b0}}, cfg.reset_margin});
    assign lim_s     = $signed({{(SW-tpf_pkg::ANGLE_W){1'b0}}, limit});

    // Freeze the firing angle once the phase has moved past it.
    assign hold      = (!fired_reg && (deg_s > alpha_new + lm_s) && (deg_s < lim_s))
                       || freeze_reg;
    assign alpha_eff = hold ? prev_s : alpha_new;
    assign freeze_a  = freeze_reg | hold;

    // Gate window and reset window.
    assign win_top = alpha_eff + pw_s;
    assign in_win  = (deg_s >= alpha_eff) && (deg_s <= win_top);
    assign out_win = (deg_s < alpha_eff - rm_s) || (deg_s > win_top);

    // Next state of the gate; reset window wins over the firing window.
    always_comb
    begin
        prev_next = alpha_eff[ANGLE_BITS-1:0];
        if (run)
        begin
            fired_next  = (fired_reg | in_win) & ~out_win;
            gate_next   = (gate_reg | in_win) & ~out_win;
            freeze_next = freeze_a & ~out_win;
        end
        else
        begin
            fired_next  = fired_reg;
            gate_next   = 1'b0;
            freeze_next = freeze_a;
        end
    end

    // Gate state advances once per transfer into the result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            fired_reg  <= 1'b0;
            freeze_reg <= 1'b0;
            gate_reg   <= 1'b0;
        end
        else if (step)
        begin
            prev_reg   <= prev_next;
            fired_reg  <= fired_next;
            freeze_reg <= freeze_next;
            gate_reg   <= gate_next;
        end
    end

    assign gate = gate_reg;

endmodule

[sv/three_phase_thyristor_firing.sv]
// Three-phase thyristor firing pulse generator, top level.
// A result moves from the input register into the gate state registers once the output is free.
// Throughput: one item per cycle while the output is not stalled; the per-gate state updates once per item.
// The input register fills while a finished result waits, so it holds the next item when the stall ends.
// Reset (asynchronous, active low) clears all gate, fired and freeze marks, stored
// angles and valid flags, and loads the configuration registers with their defaults.
`timescale 1ns / 1ps

module three_phase_thyristor_firing
#(
    parameter int ANGLE_BITS = 14
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [tpf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tpf_pkg::ANGLE_W-1:0]   angle_ab,
    input  logic [tpf_pkg::ANGLE_W-1:0]   angle_bc,
    input  logic [tpf_pkg::ANGLE_W-1:0]   angle_ca,
    input  logic [tpf_pkg::ANGLE_W-1:0]   request_ab,
    input  logic [tpf_pkg::ANGLE_W-1:0]   request_bc,
    input  logic [tpf_pkg::ANGLE_W-1:0]   request_ca,
    input  logic                          run,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          gate_a_pos,
    output logic                          gate_a_neg,
    output logic                          gate_b_pos,
    output logic                          gate_b_neg,
    output logic                          gate_c_pos,
    output logic                          gate_c_neg
);

    tpf_pkg::cfg_t cfg;

    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         run_reg;
    logic [tpf_pkg::ANGLE_W-1:0]  angle_reg [3];
    logic [tpf_pkg::ANGLE_W-1:0]  request_reg [3];
    logic                         in_xfer;
    logic                         step;
    logic                         gate_w [6];

    tpf_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the input stage moves on whenever the result stage is free.
    assign step     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || step;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register, loaded on each input transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            angle_reg[0]   <= angle_ab;
            angle_reg[1]   <= angle_bc;
            angle_reg[2]   <= angle_ca;
            request_reg[0] <= request_ab;
            request_reg[1] <= request_bc;
            request_reg[2] <= request_ca;
            run_reg        <= run;
        end
    end

    // Per phase: corrected and wrapped angle, clamped and shifted firing angles.
    for (genvar p = 0; p < 3; p++)
    begin : g_phase
        logic signed [tpf_pkg::DEG_W-1:0] deg_sum;
        logic signed [tpf_pkg::DEG_W-1:0] deg_hi;
        logic signed [tpf_pkg::DEG_W-1:0] deg_w;
        logic [tpf_pkg::ANGLE_W-1:0]      alpha_pos;
        logic [tpf_pkg::CFG_W-1:0]        alpha_pos_w;
        logic [tpf_pkg::CFG_W-1:0]        alpha_rev;

        assign deg_sum = $signed({{(tpf_pkg::DEG_W-tpf_pkg::ANGLE_W){1'b0}}, angle_reg[p]})
                         + {{(tpf_pkg::DEG_W-tpf_pkg::CFG_W){cfg.phase_correction[
                             tpf_pkg::CFG_W-1]}}, cfg.phase_correction};
        assign deg_hi  = (deg_sum > tpf_pkg::FULL_TURN) ? deg_sum - tpf_pkg::FULL_TURN
                                                        : deg_sum;
        assign deg_w   = (deg_hi < 0) ? deg_hi + tpf_pkg::FULL_TURN : deg_hi;

        // Upper limit first; with crossed limits a request above it gets the upper one, else the lower.
        assign alpha_pos = (request_reg[p] > cfg.alpha_high_limit) ? cfg.alpha_high_limit :
                           (request_reg[p] < cfg.alpha_low_limit)  ? cfg.alpha_low_limit  :
                           request_reg[p];
        assign alpha_pos_w = {1'b0, alpha_pos};
        assign alpha_rev   = {1'b0, request_reg[p]} + tpf_pkg::HALF_TURN;

        tpf_gate_cell #(.ANGLE_BITS(ANGLE_BITS)) u_pos
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .step     (step),
            .run      (run_reg),
            .deg      (deg_w),
            .alpha_in (alpha_pos_w),
            .limit    (cfg.positive_latch_limit),
            .cfg      (cfg),
            .gate     (gate_w[2*p])
        );

        tpf_gate_cell #(.ANGLE_BITS(ANGLE_BITS)) u_neg
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .step     (step),
            .run      (run_reg),
            .deg      (deg_w),
            .alpha_in (alpha_rev),
            .limit    (cfg.negative_latch_limit),
            .cfg      (cfg),
            .gate     (gate_w[2*p+1])
        );
    end

    // The gate state registers double as the result register.
    assign out_valid  = out_valid_reg;
    assign gate_a_pos = gate_w[0];
    assign gate_a_neg = gate_w[1];
    assign gate_b_pos = gate_w[2];
    assign gate_b_neg = gate_w[3];
    assign gate_c_pos = gate_w[4];
    assign gate_c_neg = gate_w[5];

endmodule

[sv/tpf_checker.sv]
// Port-level checker for the three-phase thyristor firing block, with its bind.
// Depends on three_phase_thyristor_firing_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`include "three_phase_thyristor_firing_assert.svh"

module tpf_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          run,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          gate_a_pos,
    input  logic                          gate_a_neg,
    input  logic                          gate_b_pos,
    input  logic                          gate_b_neg,
    input  logic                          gate_c_pos,
    input  logic                          gate_c_neg
);

    logic       out_stall;
    logic       out_free;
    logic       in_xfer;
    logic       off_xfer;
    logic       any_gate;
    logic [5:0] gate_bits;

    assign out_stall = out_valid && !out_ready;
    assign out_free  = !out_valid || out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign off_xfer  = in_xfer && !run;
    assign gate_bits = {gate_c_neg, gate_c_pos, gate_b_neg, gate_b_pos, gate_a_neg, gate_a_pos};
    assign any_gate  = |gate_bits;

    // A stalled result stays offered.
    `TPF_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "result withdrawn while stalled")

    // A stalled result keeps its gate levels.
    `TPF_ASSERT_NEXT(a_out_stable, out_stall, $stable(gate_bits), "gates changed while stalled")

    // With the output side free the block always takes input.
    `TPF_ASSERT_ALWAYS(a_ready_free, !out_stall || !out_valid ? in_ready : 1'b1,
        "input not ready while the output is free")

    // An accepted tick reaches the output once the output side is free.
    `TPF_ASSERT_SEQ(a_in_to_out, in_xfer ##1 out_free, out_valid, "accepted tick gave no result")

    // A tick with run low yields all gates off.
    `TPF_ASSERT_SEQ(a_run_off, off_xfer ##1 out_free, !any_gate, "gate active with run low")

endmodule

bind three_phase_thyristor_firing tpf_checker u_tpf_checker (.*);
